// ===== src/ggc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy graph coloring package
// Shared widths, codes, sequencer states and the structs that pass between
// the top level and the coloring sequencer.
// ----------------------------------------------------------------------------
package ggc_pkg;

  // Fixed field widths of the channels
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 11;
  localparam int VALUE_W  = 12;
  localparam int VCOUNT_W = 9;
  localparam int COLOR_W  = 8;
  localparam int TOTAL_W  = 9;

  // Default sizes of the graph stores
  localparam int DEF_MAX_VERTICES     = 256;
  localparam int DEF_MAX_EDGE_ENTRIES = 2048;

  // Command codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_OFFSET = 2'd0,
    OP_WR_NBR    = 2'd1,
    OP_RUN       = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  // Result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DEG,
    S_SEL,
    S_FLO,
    S_FHI,
    S_FWAIT,
    S_EDGE,
    S_PICK,
    S_DONE
  } state_t;

  // Command handed to the sequencer on an input transfer
  typedef struct packed {
    logic               go;
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // Result and status from the sequencer
  typedef struct packed {
    logic               valid;
    logic               idle;
    logic               kind;
    logic [COLOR_W-1:0] color;
    logic [TOTAL_W-1:0] color_total;
    logic               error;
  } res_t;

endpackage

// ===== src/ggc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy graph coloring channel interfaces
// Valid/ready channels for commands, results and the configuration write.
// ----------------------------------------------------------------------------
interface ggc_in_if;
  logic                           valid;
  logic                           ready;
  logic [ggc_pkg::OPCODE_W-1:0]   opcode;
  logic [ggc_pkg::INDEX_W-1:0]    index;
  logic [ggc_pkg::VALUE_W-1:0]    value;
  modport source (output valid, output opcode, output index, output value, input ready);
  modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

interface ggc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [ggc_pkg::COLOR_W-1:0]    color;
  logic [ggc_pkg::TOTAL_W-1:0]    color_total;
  logic                           error;
  modport source (output valid, output kind, output color, output color_total,
                  output error, input ready);
  modport sink   (input valid, input kind, input color, input color_total,
                  input error, output ready);
endinterface

interface ggc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ggc_pkg::VCOUNT_W-1:0]   vertex_count;
  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface

// ===== src/ggc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy graph coloring RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ggc_ram #(
  parameter int  DEPTH = 256,
  parameter int  WIDTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ggc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy graph coloring sequencer
// Holds the graph stores and steps one shared compare unit through degree
// calculation, largest-degree selection, neighbour scan and colour choice.
// ----------------------------------------------------------------------------
module ggc_seq #(
  parameter int MAX_VERTICES     = 256,
  parameter int MAX_EDGE_ENTRIES = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ggc_pkg::cmd_t                  cmd,
  input  logic [ggc_pkg::VCOUNT_W-1:0]   vertex_count,
  output ggc_pkg::res_t                  res
);

  import ggc_pkg::*;

  localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int RA_W = $clog2(MAX_VERTICES + 1);
  localparam int EA_W = (MAX_EDGE_ENTRIES > 1) ? $clog2(MAX_EDGE_ENTRIES) : 1;
  localparam int NV_W = $clog2(MAX_VERTICES + 1);
  localparam int SC_W = $clog2(MAX_VERTICES + 2);

  state_t state_r, state_nxt;

  logic [SC_W-1:0]    vtx_r;
  logic               rd_v_r;
  logic [SC_W-1:0]    rd_idx_r;
  logic [VALUE_W-1:0] prev_r;
  logic [NV_W-1:0]    nv_r;
  logic               first_r;
  logic [VALUE_W-1:0] pdeg_r, bdeg_r;
  logic [VA_W-1:0]    pidx_r, bidx_r, u_r, c_r;
  logic               bhave_r;
  logic [VALUE_W-1:0] lo_r, hi_r, e_r;
  logic               p1_v_r, p2_v_r;
  logic [MAX_VERTICES-1:0] colored_r, used_r;
  logic [NV_W-1:0]    total_r;
  logic               err_r;

  // Memory ports
  logic               ro_we, nb_we, dg_we, vc_we;
  logic [RA_W-1:0]    ro_waddr, ro_raddr;
  logic [EA_W-1:0]    nb_waddr, nb_raddr;
  logic [VA_W-1:0]    dg_waddr, dg_raddr, vc_waddr, vc_raddr;
  logic [VALUE_W-1:0] ro_rdata, nb_rdata, dg_wdata, dg_rdata;
  logic [VA_W-1:0]    vc_rdata;

  // Shared compare unit terms
  logic               deg_issue, sel_issue, edge_issue;
  logic               deg_end, sel_end, edge_end, pick_done;
  logic [VALUE_W-1:0] hi_clamp;
  logic [VA_W-1:0]    nb_vtx, sel_vtx;
  logic               nb_ok, sel_elig, sel_take;
  logic [NV_W-1:0]    c_count, nv_start;

  ggc_ram #(.DEPTH(MAX_VERTICES + 1), .WIDTH(VALUE_W)) u_ro_ram (
    .clk(clk), .we(ro_we), .waddr(ro_waddr), .wdata(cmd.value),
    .raddr(ro_raddr), .rdata(ro_rdata)
  );

  ggc_ram #(.DEPTH(MAX_EDGE_ENTRIES), .WIDTH(VALUE_W)) u_nb_ram (
    .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(cmd.value),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

  ggc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VALUE_W)) u_dg_ram (
    .clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
    .raddr(dg_raddr), .rdata(dg_rdata)
  );

  ggc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VA_W)) u_vc_ram (
    .clk(clk), .we(vc_we), .waddr(vc_waddr), .wdata(c_r),
    .raddr(vc_raddr), .rdata(vc_rdata)
  );

  // Compare terms shared across the phases
  always_comb begin
    deg_issue  = (state_r == S_DEG) && (vtx_r <= SC_W'(nv_r));
    sel_issue  = (state_r == S_SEL) && (vtx_r < SC_W'(nv_r));
    edge_issue = (state_r == S_EDGE) && (e_r < hi_r);
    deg_end    = !deg_issue && !rd_v_r;
    sel_end    = !sel_issue && !rd_v_r;
    edge_end   = !edge_issue && !p1_v_r && !p2_v_r;
    pick_done  = !used_r[c_r] || (c_r == VA_W'(MAX_VERTICES - 1));
    hi_clamp   = (32'(ro_rdata) > 32'(MAX_EDGE_ENTRIES)) ?
                 VALUE_W'(MAX_EDGE_ENTRIES) : ro_rdata;
    nb_vtx     = nb_rdata[VA_W-1:0];
    nb_ok      = (32'(nb_rdata) < 32'(nv_r)) && colored_r[nb_vtx];
    sel_vtx    = rd_idx_r[VA_W-1:0];
    sel_elig   = first_r || (dg_rdata < pdeg_r) ||
                 ((dg_rdata == pdeg_r) && (sel_vtx > pidx_r));
    sel_take   = sel_elig && (!bhave_r || (dg_rdata > bdeg_r));
    c_count    = NV_W'(c_r) + NV_W'(1);
    nv_start   = (32'(vertex_count) < 32'(MAX_VERTICES)) ?
                 NV_W'(vertex_count) : NV_W'(MAX_VERTICES);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.go && (cmd.op == OP_RUN)) begin
          state_nxt = S_DEG;
        end else if (cmd.go && (cmd.op == OP_READ)) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_IDLE;
      S_DEG: begin
        if (deg_end) state_nxt = S_SEL;
      end
      S_SEL: begin
        if (sel_end) state_nxt = bhave_r ? S_FLO : S_DONE;
      end
      S_FLO:   state_nxt = S_FHI;
      S_FHI:   state_nxt = S_FWAIT;
      S_FWAIT: state_nxt = S_EDGE;
      S_EDGE: begin
        if (edge_end) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (pick_done) state_nxt = S_SEL;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory controls and result
  always_comb begin
    ro_we    = (state_r == S_IDLE) && cmd.go && (cmd.op == OP_WR_OFFSET) &&
               (32'(cmd.index) <= 32'(MAX_VERTICES));
    ro_waddr = RA_W'(cmd.index);
    nb_we    = (state_r == S_IDLE) && cmd.go && (cmd.op == OP_WR_NBR) &&
               (32'(cmd.index) < 32'(MAX_EDGE_ENTRIES));
    nb_waddr = EA_W'(cmd.index);
    nb_raddr = EA_W'(e_r);
    unique case (state_r)
      S_FLO:   ro_raddr = RA_W'(u_r);
      S_FHI:   ro_raddr = RA_W'(u_r) + RA_W'(1);
      default: ro_raddr = vtx_r[RA_W-1:0];
    endcase
    dg_we    = (state_r == S_DEG) && rd_v_r && (rd_idx_r != '0);
    dg_waddr = VA_W'(rd_idx_r - SC_W'(1));
    dg_wdata = (ro_rdata > prev_r) ? (ro_rdata - prev_r) : '0;
    dg_raddr = vtx_r[VA_W-1:0];
    vc_we    = (state_r == S_PICK) && pick_done;
    vc_waddr = u_r;
    vc_raddr = (state_r == S_EDGE) ? nb_vtx : VA_W'(cmd.index);

    res.valid       = (state_r == S_READ) || (state_r == S_DONE);
    res.idle        = (state_r == S_IDLE);
    res.kind        = (state_r == S_READ) ? KIND_READ : KIND_RUN;
    res.color       = ((state_r == S_READ) && !err_r) ? COLOR_W'(vc_rdata) : '0;
    res.color_total = TOTAL_W'(total_r);
    res.error       = (state_r == S_READ) && err_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_v_r    <= 1'b0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      colored_r <= '0;
      used_r    <= '0;
      total_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= deg_issue || sel_issue;
      p1_v_r  <= edge_issue;
      p2_v_r  <= p1_v_r && nb_ok && (state_r == S_EDGE);
      if ((state_r == S_IDLE) && cmd.go && (cmd.op == OP_RUN)) begin
        colored_r <= '0;
        total_r   <= '0;
      end
      if (state_r == S_FWAIT) begin
        used_r <= '0;
      end
      if ((state_r == S_EDGE) && p2_v_r) begin
        used_r[vc_rdata] <= 1'b1;
      end
      if ((state_r == S_PICK) && pick_done) begin
        colored_r[u_r] <= 1'b1;
        if (c_count > total_r) total_r <= c_count;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r <= vtx_r;
    if ((state_r == S_IDLE) && cmd.go) begin
      nv_r    <= nv_start;
      vtx_r   <= '0;
      first_r <= 1'b1;
      err_r   <= (32'(cmd.index) >= 32'(vertex_count)) ||
                 (32'(cmd.index) >= 32'(MAX_VERTICES));
    end
    // Degree pass: consecutive offsets give each degree
    if (state_r == S_DEG) begin
      if (deg_issue) vtx_r <= vtx_r + SC_W'(1);
      if (rd_v_r) prev_r <= ro_rdata;
      if (deg_end) begin
        vtx_r   <= '0;
        bhave_r <= 1'b0;
      end
    end
    // Selection pass: largest remaining degree, lowest index on ties
    if (state_r == S_SEL) begin
      if (sel_issue) vtx_r <= vtx_r + SC_W'(1);
      if (rd_v_r && sel_take) begin
        bhave_r <= 1'b1;
        bdeg_r  <= dg_rdata;
        bidx_r  <= sel_vtx;
      end
      if (sel_end) begin
        u_r     <= bidx_r;
        pdeg_r  <= bdeg_r;
        pidx_r  <= bidx_r;
        first_r <= 1'b0;
      end
    end
    if (state_r == S_FHI) lo_r <= ro_rdata;
    if (state_r == S_FWAIT) begin
      hi_r <= hi_clamp;
      e_r  <= lo_r;
      c_r  <= '0;
    end
    if (edge_issue) e_r <= e_r + VALUE_W'(1);
    // Smallest free colour, one candidate a cycle
    if (state_r == S_PICK) begin
      if (pick_done) begin
        vtx_r   <= '0;
        bhave_r <= 1'b0;
      end else begin
        c_r <= c_r + VA_W'(1);
      end
    end
  end

endmodule

// ===== src/greedy_graph_coloring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy graph coloring
// Largest-degree-first greedy vertex colouring of a graph held in compressed
// sparse row form, with a configuration register for the vertex count.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   opcode, index, value
//   out_ch   out  valid/ready   kind, color, color_total, error
//   cfg_ch   in   valid/ready   vertex_count
//
// Offset and neighbour writes go straight into the stores; a colour read holds
// off the input while the sequencer is in its read state, and its result passes
// through that state and then the output register. The length of a run is set
// by the single read port of the degree memory in each selection pass. Reset is
// synchronous and active low; the stores hold no reset values. A stalled result
// holds the output register and no new command is taken until it is transferred.
// ----------------------------------------------------------------------------
module greedy_graph_coloring #(
  parameter int MAX_VERTICES     = ggc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGE_ENTRIES = ggc_pkg::DEF_MAX_EDGE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  ggc_in_if.sink     in_ch,
  ggc_out_if.source  out_ch,
  ggc_cfg_if.sink    cfg_ch
);

  import ggc_pkg::*;

  logic [VCOUNT_W-1:0] vcount_r;
  logic                out_valid_r;
  logic                kind_r, error_r;
  logic [COLOR_W-1:0]  color_r;
  logic [TOTAL_W-1:0]  total_r;
  cmd_t                cmd;
  res_t                seq_res;
  logic                in_xfer;

  // Command handshake
  assign in_ch.ready = seq_res.idle && (!out_valid_r || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cmd.go    = in_xfer;
    cmd.op    = op_t'(in_ch.opcode);
    cmd.index = in_ch.index;
    cmd.value = in_ch.value;
  end

  ggc_seq #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_EDGE_ENTRIES(MAX_EDGE_ENTRIES)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .vertex_count(vcount_r), .res(seq_res)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_ch.valid) begin
      vcount_r <= cfg_ch.vertex_count;
    end
  end

  // Result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res.valid) begin
      kind_r  <= seq_res.kind;
      color_r <= seq_res.color;
      total_r <= seq_res.color_total;
      error_r <= seq_res.error;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.color       = color_r;
  assign out_ch.color_total = total_r;
  assign out_ch.error       = error_r;

`ifndef NO_ASSERTIONS
  // A new result never overwrites one still waiting for transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seq_res.valid |-> (!out_valid_r || $past(out_ch.ready)))
    else $error("result overwrote a pending output");

  // A colour read answers in the following cycle.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (cmd.op == OP_READ)) |=> (seq_res.valid && seq_res.kind == KIND_READ))
    else $error("colour read did not answer in time");

  // Run results carry neither a colour nor an error.
  a_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_RUN)) |-> (!error_r && (color_r == '0)))
    else $error("run result with colour or error set");

  // An errored read reports colour zero.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && error_r) |-> (color_r == '0))
    else $error("errored read with non-zero colour");
`endif

endmodule
